// ===== rtl/mpq_pkg.sv =====
package mpq_pkg;

  // Queue size and the widths that follow from it.
  localparam int CAPACITY = 64;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int FILL_W   = 7;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [CNT_W-1:0] cnt_t;

  // One stored entry: {row, column, priority}.
  typedef logic [31:0] entry_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [5:0] {
    S_IDLE    = 6'b000001,
    S_CHECK   = 6'b000010,
    S_SCAN    = 6'b000100,
    S_LAST_RD = 6'b001000,
    S_SWAP    = 6'b010000,
    S_FINISH  = 6'b100000
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    take;
    logic    res_set;
    status_t res_status;
    logic    enq_wr;
    logic    scan_start;
    logic    scan_rd;
    logic    last_rd;
    logic    swap;
    logic    load_out;
  } mpq_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic in_valid;
    logic is_enq;
    logic full;
    logic empty;
    logic scan_last;
    logic out_free;
  } mpq_stat_t;

  // Entry count as reported on the output, modulo 128.
  function automatic logic [FILL_W-1:0] fill_of(cnt_t c);
    logic [CNT_W+FILL_W-1:0] w;
    w = {{FILL_W{1'b0}}, c};
    return w[FILL_W-1:0];
  endfunction

endpackage

// ===== rtl/mpq_if.sv =====
// Request channel: one enqueue or dequeue command per item.
interface mpq_req_if;
  logic        valid;
  logic        ready;
  logic        mode;
  logic [7:0]  pos_row;
  logic [7:0]  pos_col;
  logic [15:0] prio;

  modport source (output valid, mode, pos_row, pos_col, prio, input ready);
  modport sink   (input valid, mode, pos_row, pos_col, prio, output ready);
endinterface

// Response channel: one result item per request item.
interface mpq_rsp_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_row;
  logic [7:0]  out_col;
  logic [15:0] out_prio;
  logic        out_valid;
  logic [1:0]  status;
  logic [6:0]  fill_count;

  modport source (output valid, out_row, out_col, out_prio, out_valid, status, fill_count,
                  input ready);
  modport sink   (input valid, out_row, out_col, out_prio, out_valid, status, fill_count,
                  output ready);
endinterface

// ===== rtl/min_priority_queue_scan_top.sv =====
// Channel  Role    Payload
// req      sink    mode, pos_row, pos_col, prio
// rsp      source  out_row, out_col, out_prio, out_valid, status, fill_count
//
// An enqueue, or a dequeue of an empty queue, goes from acceptance through
// the check state to the finish state; other dequeues also run the scan, the
// last read and the swap, growing with the number of stored entries, read by
// the scan through the single read port of the store, one entry a cycle.
// Reset is synchronous and empties the queue; the store needs no clearing.
// A new item is accepted while a result waits in the output register; a
// stalled result only holds the block at the end of the following item.
module min_priority_queue_scan_top
  import mpq_pkg::*;
(
  input logic   clk,
  input logic   rst,
  mpq_req_if.sink   req,
  mpq_rsp_if.source rsp
);

  mpq_cmd_t  cmd;
  mpq_stat_t st;

  mpq_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .st  (st),
    .cmd (cmd)
  );

  mpq_dp u_dp (
    .clk (clk),
    .rst (rst),
    .cmd (cmd),
    .st  (st),
    .req (req),
    .rsp (rsp)
  );

endmodule

// ===== rtl/mpq_ctrl.sv =====
module mpq_ctrl
  import mpq_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  mpq_stat_t st,
  output mpq_cmd_t  cmd
);

  state_t state;
  state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sequencing of one item: check, then scan and swap for a non-empty dequeue, then hand the result on.
  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        cmd.take = 1'b1;
        if (st.in_valid) begin
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (st.is_enq) begin
          cmd.res_set = 1'b1;
          if (st.full) begin
            cmd.res_status = ST_FULL;
          end else begin
            cmd.res_status = ST_OK;
            cmd.enq_wr     = 1'b1;
          end
          state_next = S_FINISH;
        end else if (st.empty) begin
          cmd.res_set    = 1'b1;
          cmd.res_status = ST_EMPTY;
          state_next     = S_FINISH;
        end else begin
          cmd.scan_start = 1'b1;
          state_next     = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan_rd = 1'b1;
        if (st.scan_last) begin
          state_next = S_LAST_RD;
        end
      end
      S_LAST_RD: begin
        cmd.last_rd = 1'b1;
        state_next  = S_SWAP;
      end
      S_SWAP: begin
        cmd.swap   = 1'b1;
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (st.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/mpq_dp.sv =====
module mpq_dp
  import mpq_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  mpq_cmd_t      cmd,
  output mpq_stat_t     st,
  mpq_req_if.sink       req,
  mpq_rsp_if.source     rsp
);

  entry_t mem [CAPACITY];
  entry_t rd_data;
  idx_t   rd_addr;

  logic        item_mode;
  entry_t      item_entry;
  cnt_t        count;
  idx_t        scan_idx;
  logic        cmp_valid;
  idx_t        cmp_addr;
  idx_t        best_idx;
  entry_t      best_entry;
  entry_t      res_entry;
  logic        res_valid;
  status_t     res_status;
  logic        out_vld;
  entry_t      out_entry;
  logic        out_ok;
  status_t     out_status;
  logic [6:0]  out_fill;
  idx_t        last_idx;
  cnt_t        count_m1;
  logic        accept;
  logic        better;

  assign accept   = cmd.take & req.valid;
  assign count_m1 = count - cnt_t'(1);
  assign last_idx = count_m1[IDX_W-1:0];
  assign rd_addr  = cmd.last_rd ? last_idx : scan_idx;
  assign better   = (cmp_addr == '0) || (rd_data[15:0] < best_entry[15:0]);

  // Status towards the controller.
  always_comb begin
    st.in_valid  = req.valid;
    st.is_enq    = ~item_mode;
    st.full      = (count >= cnt_t'(CAPACITY));
    st.empty     = (count == '0);
    st.scan_last = (cnt_t'(scan_idx) == count_m1);
    st.out_free  = ~out_vld | rsp.ready;
  end

  // Entry store: one write port and one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.enq_wr) begin
      mem[count[IDX_W-1:0]] <= item_entry;
    end else if (cmd.swap) begin
      mem[best_idx] <= rd_data;
    end
    rd_data <= mem[rd_addr];
  end

  // Latched request item.
  always_ff @(posedge clk) begin
    if (accept) begin
      item_mode  <= req.mode;
      item_entry <= {req.pos_row, req.pos_col, req.prio};
    end
  end

  // Entry count.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.enq_wr) begin
      count <= count + cnt_t'(1);
    end else if (cmd.swap) begin
      count <= count_m1;
    end
  end

  // Scan address and the compare, which works on the data in the cycle after its read.
  always_ff @(posedge clk) begin
    if (rst) begin
      cmp_valid <= 1'b0;
    end else begin
      cmp_valid <= cmd.scan_rd;
    end
    if (cmd.scan_start) begin
      scan_idx <= '0;
    end else if (cmd.scan_rd) begin
      scan_idx <= scan_idx + idx_t'(1);
    end
    cmp_addr <= scan_idx;
    if (cmp_valid && better) begin
      best_idx   <= cmp_addr;
      best_entry <= rd_data;
    end
  end

  // Result of the current item.
  always_ff @(posedge clk) begin
    if (cmd.res_set) begin
      res_entry  <= '0;
      res_valid  <= 1'b0;
      res_status <= cmd.res_status;
    end else if (cmd.swap) begin
      res_entry  <= best_entry;
      res_valid  <= 1'b1;
      res_status <= ST_OK;
    end
  end

  // Output register, which lets the next item start while a result waits.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (cmd.load_out) begin
      out_vld <= 1'b1;
    end else if (rsp.ready) begin
      out_vld <= 1'b0;
    end
    if (cmd.load_out) begin
      out_entry  <= res_entry;
      out_ok     <= res_valid;
      out_status <= res_status;
      out_fill   <= fill_of(count);
    end
  end

  assign req.ready      = cmd.take;
  assign rsp.valid      = out_vld;
  assign rsp.out_row    = out_entry[31:24];
  assign rsp.out_col    = out_entry[23:16];
  assign rsp.out_prio   = out_entry[15:0];
  assign rsp.out_valid  = out_ok;
  assign rsp.status     = out_status;
  assign rsp.fill_count = out_fill;

`ifndef ASSERT_OFF
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= cnt_t'(CAPACITY))
    else $error("entry count exceeds capacity");

  a_no_write_full: assert property (@(posedge clk) disable iff (rst)
    cmd.enq_wr |-> count < cnt_t'(CAPACITY))
    else $error("enqueue write into a full store");

  a_swap_dec: assert property (@(posedge clk) disable iff (rst)
    cmd.swap |=> count == $past(count) - cnt_t'(1))
    else $error("dequeue did not decrement the count");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.scan_rd |-> cnt_t'(scan_idx) < count)
    else $error("scan reads beyond the stored entries");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!out_vld || rsp.ready))
    else $error("result loaded over an untaken result");
`endif

endmodule

// ===== test/min_priority_queue_scan_top_tb.sv =====
`timescale 1ns / 1ps

module min_priority_queue_scan_top_tb
  import mpq_pkg::*;
();

  // Request codes carried in the mode field.
  localparam logic MODE_ENQ = 1'b0;
  localparam logic MODE_DEQ = 1'b1;

  // The tail wait covers a dequeue of a full queue, with a margin on top.
  localparam int TAIL_CYCLES  = CAPACITY + 16;
  localparam int HOLD_CYCLES  = 300;
  localparam int CYCLE_LIMIT  = 500000;

  // One result item as the queue should report it.
  typedef struct {
    logic [7:0]  row;
    logic [7:0]  col;
    logic [15:0] prio;
    logic        valid;
    status_t     status;
    logic [6:0]  fill;
  } queue_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  mpq_req_if req_ch ();
  mpq_rsp_if rsp_ch ();

  min_priority_queue_scan_top u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // Shadow copy of the queue contents, updated as each request item is accepted.
  entry_t        shadow_entries [CAPACITY];
  int            shadow_count;
  queue_result_t awaited_results [$];

  int   mismatch_count;
  int   cycle_count;
  int   sender_idle_pct;
  int   recv_stall_pct;
  logic rsp_hold;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Work out the result of one request and update the shadow queue.
  function automatic queue_result_t apply_queue_op(input logic mode, input logic [7:0] row,
                                                   input logic [7:0] col,
                                                   input logic [15:0] prio);
    queue_result_t r;
    int            best;
    entry_t        found;
    r.row    = '0;
    r.col    = '0;
    r.prio   = '0;
    r.valid  = 1'b0;
    r.status = ST_OK;
    if (mode == MODE_ENQ) begin
      if (shadow_count >= CAPACITY) begin
        r.status = ST_FULL;
      end else begin
        shadow_entries[shadow_count] = {row, col, prio};
        shadow_count++;
      end
    end else if (shadow_count == 0) begin
      r.status = ST_EMPTY;
    end else begin
      // Smallest priority wins; a strict compare keeps the lowest slot on a tie.
      best = 0;
      for (int i = 1; i < shadow_count; i++) begin
        if (shadow_entries[i][15:0] < shadow_entries[best][15:0]) begin
          best = i;
        end
      end
      found = shadow_entries[best];
      shadow_entries[best] = shadow_entries[shadow_count - 1];
      shadow_count--;
      r.row   = found[31:24];
      r.col   = found[23:16];
      r.prio  = found[15:0];
      r.valid = 1'b1;
    end
    r.fill = shadow_count[6:0];
    return r;
  endfunction

  // Offer one request item, idling beforehand as the current phase asks.
  task automatic send_item(input logic mode, input logic [7:0] row, input logic [7:0] col,
                           input logic [15:0] prio);
    while ($urandom_range(99) < sender_idle_pct) begin
      @(negedge clk);
      req_ch.valid = 1'b0;
    end
    @(negedge clk);
    req_ch.valid   = 1'b1;
    req_ch.mode    = mode;
    req_ch.pos_row = row;
    req_ch.pos_col = col;
    req_ch.prio    = prio;
    do begin
      @(posedge clk);
    end while (!req_ch.ready);
    awaited_results.push_back(apply_queue_op(mode, row, col, prio));
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      mismatch_count++;
      $display("%0t: %s differs, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  // Extremes of every field, an empty dequeue and ties between equal priorities.
  task automatic test_directed_cases();
    sender_idle_pct = 0;
    recv_stall_pct  = 0;
    send_item(MODE_DEQ, 8'hFF, 8'hFF, 16'hFFFF);
    send_item(MODE_ENQ, 8'h00, 8'h00, 16'h0000);
    send_item(MODE_ENQ, 8'hFF, 8'hFF, 16'hFFFF);
    send_item(MODE_ENQ, 8'hA5, 8'h5A, 16'h8000);
    send_item(MODE_DEQ, 8'h00, 8'h00, 16'h0000);
    send_item(MODE_DEQ, 8'h12, 8'h34, 16'h5678);
    send_item(MODE_DEQ, 8'h00, 8'h00, 16'h0000);
    send_item(MODE_DEQ, 8'h00, 8'h00, 16'h0000);
    // Equal priorities: the lowest slot is served first, and the last entry
    // moves into the hole so the slot order changes after each dequeue.
    send_item(MODE_ENQ, 8'd1, 8'd10, 16'd7);
    send_item(MODE_ENQ, 8'd2, 8'd20, 16'd7);
    send_item(MODE_ENQ, 8'd3, 8'd30, 16'd9);
    send_item(MODE_ENQ, 8'd4, 8'd40, 16'd7);
    send_item(MODE_ENQ, 8'd5, 8'd50, 16'd3);
    send_item(MODE_DEQ, 8'h00, 8'h00, 16'h0000);
    send_item(MODE_DEQ, 8'h00, 8'h00, 16'h0000);
    send_item(MODE_DEQ, 8'h00, 8'h00, 16'h0000);
    send_item(MODE_DEQ, 8'h00, 8'h00, 16'h0000);
    send_item(MODE_DEQ, 8'h00, 8'h00, 16'h0000);
    send_item(MODE_DEQ, 8'h00, 8'h00, 16'h0000);
  endtask

  // Fill the queue to capacity, push past it, then drain it completely.
  task automatic test_full_queue();
    sender_idle_pct = 0;
    recv_stall_pct  = 25;
    while (shadow_count < CAPACITY) begin
      send_item(MODE_ENQ, 8'($urandom_range(255)), 8'($urandom_range(255)),
                16'($urandom_range(65535)));
    end
    repeat (3) begin
      send_item(MODE_ENQ, 8'($urandom_range(255)), 8'($urandom_range(255)),
                16'($urandom_range(65535)));
    end
    while (shadow_count > 0) begin
      send_item(MODE_DEQ, 8'($urandom_range(255)), 8'($urandom_range(255)),
                16'($urandom_range(65535)));
    end
    send_item(MODE_DEQ, 8'h00, 8'h00, 16'h0000);
  endtask

  // Mixed traffic that keeps the queue mostly shallow, with narrow priority
  // ranges half of the time so that ties are common.
  task automatic test_random_traffic(input int n_items, input int send_pct,
                                     input int recv_pct);
    int   enq_pct;
    logic mode;
    logic [15:0] prio;
    sender_idle_pct = send_pct;
    recv_stall_pct  = recv_pct;
    repeat (n_items) begin
      if (shadow_count == 0) begin
        enq_pct = 85;
      end else if (shadow_count < 4) begin
        enq_pct = 65;
      end else if (shadow_count < 12) begin
        enq_pct = 50;
      end else begin
        enq_pct = 30;
      end
      mode = ($urandom_range(99) < enq_pct) ? MODE_ENQ : MODE_DEQ;
      prio = ($urandom_range(1) == 0) ? 16'($urandom_range(3)) : 16'($urandom_range(65535));
      send_item(mode, 8'($urandom_range(255)), 8'($urandom_range(255)), prio);
    end
  endtask

  // Hold the response channel off for a long stretch while requests keep coming,
  // so that the block fills its output and stalls its input.
  task automatic test_output_backpressure();
    sender_idle_pct = 0;
    recv_stall_pct  = 0;
    fork
      begin
        rsp_hold = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rsp_hold = 1'b0;
      end
    join_none
    repeat (6) begin
      send_item(MODE_ENQ, 8'($urandom_range(255)), 8'($urandom_range(255)),
                16'($urandom_range(65535)));
    end
    repeat (7) begin
      send_item(MODE_DEQ, 8'($urandom_range(255)), 8'($urandom_range(255)),
                16'($urandom_range(65535)));
    end
  endtask

  // Receiver: ready changes on the falling edge.
  always @(negedge clk) begin
    rsp_ch.ready = !rsp_hold && ($urandom_range(99) >= recv_stall_pct);
  end

  // Each accepted result item is matched against the oldest expectation.
  always @(posedge clk) begin : rsp_check
    queue_result_t want;
    if (!rst && rsp_ch.valid === 1'b1 && rsp_ch.ready) begin
      if (awaited_results.size() == 0) begin
        mismatch_count++;
        $display("%0t: result item with none expected, expected nothing, actual row %0d col %0d",
                 $time, rsp_ch.out_row, rsp_ch.out_col);
      end else begin
        want = awaited_results.pop_front();
        check_field("out_row", want.row, rsp_ch.out_row);
        check_field("out_col", want.col, rsp_ch.out_col);
        check_field("out_prio", want.prio, rsp_ch.out_prio);
        check_field("out_valid", want.valid, rsp_ch.out_valid);
        check_field("status", want.status, rsp_ch.status);
        check_field("fill_count", want.fill, rsp_ch.fill_count);
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    req_ch.valid    = 1'b0;
    req_ch.mode     = MODE_ENQ;
    req_ch.pos_row  = '0;
    req_ch.pos_col  = '0;
    req_ch.prio     = '0;
    rsp_hold        = 1'b0;
    shadow_count    = 0;
    mismatch_count  = 0;
    cycle_count     = 0;
    sender_idle_pct = 0;
    recv_stall_pct  = 0;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed_cases();
    test_full_queue();
    test_random_traffic(60, 0, 0);
    test_random_traffic(60, 76, 0);
    test_random_traffic(60, 0, 76);
    test_random_traffic(60, 25, 25);
    test_output_backpressure();

    @(negedge clk);
    req_ch.valid = 1'b0;

    // Let every awaited result arrive, then watch for stray ones.
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && awaited_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
